// File: rtl/ass_pkg.sv
// adaptive sample stop: shared types, register indexes, stop causes and sequencer states
// no dependencies
`timescale 1ns / 1ps
package ass_pkg;

  localparam int SampleW = 32;
  localparam int CountW  = 32;
  localparam int SqW     = 64;
  localparam int MplW    = 64;
  localparam int BigW    = 192;
  localparam int CfgW    = 16;
  localparam int CapW    = 11;
  localparam int CfgIdxW = 3;
  localparam int CntW    = 6;
  localparam int QShift  = 24;

  localparam logic [CfgIdxW-1:0] REG_TARGET  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CAP     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAXERR  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_QUANT   = 3'd4;

  localparam logic [CfgW-1:0] TARGET_RST = 16'd4;
  localparam logic [CapW-1:0] CAP_RST    = 11'd32;
  localparam logic [CfgW-1:0] GAIN_RST   = 16'd1024;
  localparam logic [CfgW-1:0] MAXERR_RST = 16'd205;
  localparam logic [CfgW-1:0] QUANT_RST  = 16'd8028;

  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_CAP  = 2'd1;
  localparam logic [1:0] CAUSE_CONV = 2'd2;

  typedef struct packed {
    logic [CfgW-1:0]        target;
    logic signed [CapW-1:0] cap_factor;
    logic [CfgW-1:0]        gain;
    logic [CfgW-1:0]        max_err;
    logic [CfgW-1:0]        quant;
  } cfg_t;

  typedef struct packed {
    logic               stop;
    logic [1:0]         cause;
    logic [CountW-1:0]  count;
    logic [SampleW-1:0] mean;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_D1, ST_D1N, ST_DIV, ST_UPD, ST_D2, ST_MPRD, ST_SQ, ST_MNN,
    ST_MA1, ST_MA2, ST_MA3, ST_MA4, ST_MQ2, ST_MRHS, ST_CMP, ST_DONE
  } state_t;

endpackage

// File: rtl/ass_if.sv
// adaptive sample stop: valid/ready channel interfaces for sample and result beats
// depends on ass_pkg
`timescale 1ns / 1ps
interface ass_in_if;
  logic                       valid;
  logic                       ready;
  logic [ass_pkg::SampleW-1:0] sample;
  logic                       first;
  modport source (output valid, sample, first, input ready);
  modport sink (input valid, sample, first, output ready);
endinterface

interface ass_out_if;
  logic                       valid;
  logic                       ready;
  logic                       stop;
  logic [1:0]                 stop_cause;
  logic [ass_pkg::CountW-1:0]  sample_count;
  logic [ass_pkg::SampleW-1:0] running_mean;
  modport source (output valid, stop, stop_cause, sample_count, running_mean, input ready);
  modport sink (input valid, stop, stop_cause, sample_count, running_mean, output ready);
endinterface

// File: rtl/adaptive_sample_stop.sv
// adaptive sample stop top level: configuration registers, core and result register
// depends on ass_pkg, ass_if and ass_core
//
// usage
// - in_ch carries one luminance beat (sample, Q16.16 unsigned, and first) per
//   sample of the pixel; first restarts count, mean and m2 before the sample
// - out_ch returns one beat per sample: stop, stop_cause, sample_count and
//   running_mean after the update
// - cfg_we/cfg_idx/cfg_wdata write target, cap factor, gain, max error and
//   quantile; write only while the block is idle
// - the exact convergence test runs only when the cap does not fire and the
//   count has reached target and two; a sample below the mean passes an extra
//   state (ST_D1N); one beat at a time, the next beat is taken in the cycle
//   after the result leaves the core
// - the datapath uses one shared 192-bit adder: a 32-step restoring divide for
//   the mean, then shift-add multiplies one multiplier bit per cycle
// - in_ch.ready is high only while the sequencer is idle
// - a finished result sits in an output register, so a new beat is taken
//   while the receiver stalls; a second result waits in the core
// - reset (rst_n low, synchronous) clears statistics and loads register defaults
`timescale 1ns / 1ps
module adaptive_sample_stop (
  input  logic                        clk,
  input  logic                        rst_n,
  ass_in_if.sink                      in_ch,
  ass_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [ass_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [ass_pkg::CfgW-1:0]    cfg_wdata
);
  import ass_pkg::*;

  cfg_t cfg_r;
  res_t res, out_r;
  logic res_valid, res_ready, core_ready;
  logic out_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target     <= TARGET_RST;
      cfg_r.cap_factor <= CAP_RST;
      cfg_r.gain       <= GAIN_RST;
      cfg_r.max_err    <= MAXERR_RST;
      cfg_r.quant      <= QUANT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TARGET: cfg_r.target     <= cfg_wdata;
        REG_CAP:    cfg_r.cap_factor <= cfg_wdata[CapW-1:0];
        REG_GAIN:   cfg_r.gain       <= cfg_wdata;
        REG_MAXERR: cfg_r.max_err    <= cfg_wdata;
        REG_QUANT:  cfg_r.quant      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ass_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (core_ready),
    .in_sample (in_ch.sample),
    .in_first  (in_ch.first),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign in_ch.ready = core_ready;

  // result register, frees the core while the receiver stalls
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.stop         = out_r.stop;
  assign out_ch.stop_cause   = out_r.cause;
  assign out_ch.sample_count = out_r.count;
  assign out_ch.running_mean = out_r.mean;

endmodule

// File: rtl/ass_alu.sv
// adaptive sample stop: shared wide adder/subtractor, carry out flags a >= b on subtract
// depends on ass_pkg
`timescale 1ns / 1ps
module ass_alu (
  input  logic [ass_pkg::BigW-1:0] a,
  input  logic [ass_pkg::BigW-1:0] b,
  input  logic                     sub,
  output logic [ass_pkg::BigW:0]   sum
);
  import ass_pkg::*;

  logic [BigW-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign sum  = {1'b0, a} + {1'b0, b_op} + {{BigW{1'b0}}, sub};

endmodule

// File: rtl/ass_core.sv
// adaptive sample stop: sequencer and datapath, welford update and exact stop test
// depends on ass_pkg and ass_alu
`timescale 1ns / 1ps
module ass_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ass_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ass_pkg::SampleW-1:0] in_sample,
  input  logic                        in_first,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ass_pkg::res_t               res
);
  import ass_pkg::*;

  state_t state_r, state_nxt;

  logic [CountW-1:0]  count_r;
  logic [SampleW-1:0] mean_r, s_r, d1_r, d2_r, quo_r, rem_r;
  logic [SqW-1:0]     sq_r;
  logic [MplW-1:0]    nn_r, mplier_r;
  logic [BigW-1:0]    mcand_r, acc_r, lhs_r, acc_step;
  logic [CntW-1:0]    cnt_r;
  logic               neg_r, stop_r;
  logic [1:0]         cause_r;

  logic [BigW-1:0] alu_a, alu_b;
  logic            alu_sub;
  logic [BigW:0]   alu_sum;
  logic [SampleW:0] rem_sh;
  logic [25:0]     cap_prod;
  logic            cap_hit, elig, last;

  ass_alu u_alu (.a(alu_a), .b(alu_b), .sub(alu_sub), .sum(alu_sum));

  assign rem_sh   = {rem_r, quo_r[SampleW-1]};
  assign acc_step = mplier_r[0] ? alu_sum[BigW-1:0] : acc_r;
  assign last     = (cnt_r == '0);
  assign cap_prod = 26'(cfg.cap_factor[CapW-2:0]) * 26'(cfg.target);
  assign cap_hit  = !cfg.cap_factor[CapW-1] && (CountW'(cap_prod) <= count_r);
  assign elig     = (count_r >= CountW'(cfg.target)) && (count_r >= CountW'(2));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_D1;
      ST_D1:   state_nxt = alu_sum[BigW] ? ST_DIV : ST_D1N;
      ST_D1N:  state_nxt = ST_DIV;
      ST_DIV:  if (last) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_D2;
      ST_D2:   state_nxt = ST_MPRD;
      ST_MPRD: if (last) state_nxt = ST_SQ;
      ST_SQ:   state_nxt = (!cap_hit && elig) ? ST_MNN : ST_DONE;
      ST_MNN:  if (last) state_nxt = ST_MA1;
      ST_MA1:  if (last) state_nxt = ST_MA2;
      ST_MA2:  if (last) state_nxt = ST_MA3;
      ST_MA3:  if (last) state_nxt = ST_MA4;
      ST_MA4:  if (last) state_nxt = ST_MQ2;
      ST_MQ2:  if (last) state_nxt = ST_MRHS;
      ST_MRHS: if (last) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_DONE;
      ST_DONE: if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and shared unit operands
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    res_valid = (state_r == ST_DONE);
    alu_a     = acc_r;
    alu_b     = mcand_r;
    alu_sub   = 1'b0;
    unique case (state_r)
      ST_D1:  begin alu_a = BigW'(s_r); alu_b = BigW'(mean_r); alu_sub = 1'b1; end
      ST_D1N: begin alu_a = BigW'(mean_r); alu_b = BigW'(s_r); alu_sub = 1'b1; end
      ST_DIV: begin alu_a = BigW'(rem_sh); alu_b = BigW'(count_r); alu_sub = 1'b1; end
      ST_UPD: begin alu_a = BigW'(mean_r); alu_b = BigW'(quo_r); alu_sub = neg_r; end
      ST_D2: begin
        alu_a   = neg_r ? BigW'(mean_r) : BigW'(s_r);
        alu_b   = neg_r ? BigW'(s_r) : BigW'(mean_r);
        alu_sub = 1'b1;
      end
      ST_SQ:  begin alu_a = BigW'(sq_r); alu_b = acc_r; end
      ST_CMP: begin alu_a = lhs_r; alu_b = acc_r; alu_sub = 1'b1; end
      default: begin alu_a = acc_r; alu_b = mcand_r; alu_sub = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      mean_r  <= '0;
      sq_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          s_r <= in_sample;
          if (in_first) begin
            count_r <= CountW'(1);
            mean_r  <= '0;
            sq_r    <= '0;
          end else if (count_r != '1) begin
            count_r <= count_r + CountW'(1);
          end
        end
        ST_D1, ST_D1N: begin
          neg_r <= (state_r == ST_D1) ? !alu_sum[BigW] : 1'b1;
          d1_r  <= alu_sum[SampleW-1:0];
          quo_r <= alu_sum[SampleW-1:0];
          rem_r <= '0;
          cnt_r <= CntW'(SampleW - 1);
        end
        ST_DIV: begin
          rem_r <= alu_sum[BigW] ? alu_sum[SampleW-1:0] : rem_sh[SampleW-1:0];
          quo_r <= {quo_r[SampleW-2:0], alu_sum[BigW]};
          cnt_r <= cnt_r - CntW'(1);
        end
        ST_UPD: mean_r <= alu_sum[SampleW-1:0];
        ST_D2: begin
          d2_r     <= alu_sum[SampleW-1:0];
          mcand_r  <= BigW'(d1_r);
          mplier_r <= MplW'(alu_sum[SampleW-1:0]);
          acc_r    <= '0;
          cnt_r    <= CntW'(SampleW - 1);
        end
        ST_SQ: begin
          sq_r    <= alu_sum[SqW] ? '1 : alu_sum[SqW-1:0];
          stop_r  <= cap_hit;
          cause_r <= cap_hit ? CAUSE_CAP : CAUSE_NONE;
          // n * (n - 1)
          mcand_r  <= BigW'(count_r);
          mplier_r <= MplW'(count_r - CountW'(1));
          acc_r    <= '0;
          cnt_r    <= CntW'(CountW - 1);
        end
        ST_CMP: if (alu_sum[BigW]) begin
          stop_r  <= 1'b1;
          cause_r <= CAUSE_CONV;
        end
        ST_DONE: ;
        default: begin
          // shift-add multiply step
          mcand_r  <= {mcand_r[BigW-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[MplW-1:1]};
          acc_r    <= acc_step;
          cnt_r    <= cnt_r - CntW'(1);
          if (last) begin
            acc_r <= '0;
            unique case (state_r)
              ST_MPRD: acc_r <= acc_step;
              ST_MNN: begin
                nn_r     <= acc_step[MplW-1:0];
                mcand_r  <= BigW'(d2_r);
                mplier_r <= MplW'(cfg.gain);
                cnt_r    <= CntW'(CfgW - 1);
              end
              ST_MA1: begin
                mcand_r  <= acc_step;
                mplier_r <= MplW'(cfg.max_err);
                cnt_r    <= CntW'(CfgW - 1);
              end
              ST_MA2: begin
                mcand_r  <= acc_step;
                mplier_r <= acc_step[MplW-1:0];
                cnt_r    <= CntW'(MplW - 1);
              end
              ST_MA3: begin
                mcand_r  <= acc_step;
                mplier_r <= nn_r;
                cnt_r    <= CntW'(MplW - 1);
              end
              ST_MA4: begin
                lhs_r    <= acc_step;
                mcand_r  <= BigW'(cfg.quant);
                mplier_r <= MplW'(cfg.quant);
                cnt_r    <= CntW'(CfgW - 1);
              end
              ST_MQ2: begin
                mcand_r  <= BigW'({sq_r, {QShift{1'b0}}});
                mplier_r <= MplW'(acc_step[2*CfgW-1:0]);
                cnt_r    <= CntW'(2 * CfgW - 1);
              end
              ST_MRHS: acc_r <= acc_step;
              default: acc_r <= acc_step;
            endcase
          end
        end
      endcase
    end
  end

  assign res.stop  = stop_r;
  assign res.cause = cause_r;
  assign res.count = count_r;
  assign res.mean  = mean_r;

endmodule

// File: sim/adaptive_sample_stop_test.sv
// adaptive sample stop testbench: drives luminance beats, predicts stop decisions, checks results
// depends on ass_pkg, ass_if and adaptive_sample_stop
`timescale 1ns / 1ps
module adaptive_sample_stop_test;
  import ass_pkg::*;

  localparam int StopLimit = 20000;  // cycles without any beat before giving up
  localparam int Drain     = 400;    // a little above the longest latency

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               first;
  } lum_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_wdata = '0;

  ass_in_if  in_ch();
  ass_out_if out_ch();

  adaptive_sample_stop i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of configuration and statistics
  logic [15:0] m_target;
  logic signed [10:0] m_capf;
  logic [15:0] m_gain, m_maxerr, m_quant;
  logic [31:0] m_count, m_mean;
  logic [63:0] m_m2;

  lum_beat_t pending_beats[$];
  res_t      expected_res[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off = 0;
  logic      long_hold_req = 1'b0;
  logic      hold_started = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TARGET: m_target = val;
      REG_CAP:    m_capf = val[CapW-1:0];
      REG_GAIN:   m_gain = val;
      REG_MAXERR: m_maxerr = val;
      REG_QUANT:  m_quant = val;
      default: ;
    endcase
  endtask

  // welford update and stop decision for one beat
  function automatic res_t predict_stop(input lum_beat_t b);
    res_t r;
    logic [31:0] n, d1, d2;
    logic [63:0] prod;
    logic [191:0] a, lhs, rhs;
    logic [63:0] cap;
    if (b.first) begin
      m_count = 0; m_mean = 0; m_m2 = 0;
    end
    if (m_count != 32'hFFFF_FFFF) m_count++;
    n = m_count;
    if (b.sample >= m_mean) begin
      d1 = b.sample - m_mean;
      m_mean = m_mean + d1 / n;
      d2 = b.sample - m_mean;
    end else begin
      d1 = m_mean - b.sample;
      m_mean = m_mean - d1 / n;
      d2 = m_mean - b.sample;
    end
    prod = 64'(d1) * 64'(d2);
    if (m_m2 > ~64'd0 - prod) m_m2 = ~64'd0;
    else m_m2 = m_m2 + prod;
    r.stop = 1'b0;
    r.cause = CAUSE_NONE;
    cap = 64'($unsigned(m_capf)) * 64'(m_target);
    if (!m_capf[CapW-1] && 64'(n) >= cap) begin
      r.stop = 1'b1;
      r.cause = CAUSE_CAP;
    end else if (n >= 32'(m_target) && n >= 2) begin
      a = 192'(d2) * 192'(m_gain) * 192'(m_maxerr);
      lhs = a * a * (192'(n) * 192'(n - 1));
      rhs = 192'(m_m2) * ((192'(m_quant) * 192'(m_quant)) << QShift);
      if (lhs >= rhs) begin
        r.stop = 1'b1;
        r.cause = CAUSE_CONV;
      end
    end
    r.count = n;
    r.mean = m_mean;
    return r;
  endfunction

  // driver: offers the head of the queue, honours the sender idle rate
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= '0;
      in_ch.first <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the beat until taken
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_res.push_back(predict_stop(pending_beats.pop_front()));
      end
      if (pending_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.sample <= pending_beats[0].sample;
        in_ch.first <= pending_beats[0].first;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_off <= 3000;
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= $urandom_range(99, 0) >= recv_stall_pct;
    end
  end

  // monitor: compares each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_res.size() == 0) begin
        report("unexpected beat", out_ch.sample_count, 32'd0);
      end else begin
        res_t e;
        e = expected_res.pop_front();
        if (out_ch.stop !== e.stop) report("stop", 32'(out_ch.stop), 32'(e.stop));
        if (out_ch.stop_cause !== e.cause)
          report("stop_cause", 32'(out_ch.stop_cause), 32'(e.cause));
        if (out_ch.sample_count !== e.count)
          report("sample_count", out_ch.sample_count, e.count);
        if (out_ch.running_mean !== e.mean)
          report("running_mean", out_ch.running_mean, e.mean);
      end
    end
  end

  // watchdog on beats in either direction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StopLimit) begin
      $display("[adaptive_sample_stop] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3, 0))
      0: return $urandom();
      1: return 32'h0001_0000 + $urandom_range(32'h0000_4000, 0);  // near 1.0, low noise
      2: return $urandom_range(32'h0004_0000, 0);
      default: return $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  // one pixel: a first beat then a run of samples, sometimes with one extra random beat
  task automatic queue_pixel(input int len);
    lum_beat_t b;
    for (int k = 0; k < len; k++) begin
      b.first = (k == 0);
      b.sample = rand_sample();
      pending_beats.push_back(b);
    end
    if ($urandom_range(9, 0) == 0) begin
      b.first = 1'($urandom_range(1, 0));
      b.sample = $urandom();
      pending_beats.push_back(b);
    end
  endtask

  task automatic wait_empty();
    while (pending_beats.size() != 0 || in_ch.valid || expected_res.size() != 0)
      @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic queue_random(input int num);
    int start;
    start = pending_beats.size();
    while (pending_beats.size() - start < num) queue_pixel($urandom_range(12, 1));
  endtask

  initial begin
    lum_beat_t b;
    m_target = TARGET_RST; m_capf = CAP_RST; m_gain = GAIN_RST;
    m_maxerr = MAXERR_RST; m_quant = QUANT_RST;
    m_count = 0; m_mean = 0; m_m2 = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, constant pixel (zero variance converges), single sample
    b.first = 1'b1; b.sample = 32'h0;          pending_beats.push_back(b);
    b.first = 1'b0; b.sample = 32'hFFFF_FFFF;  pending_beats.push_back(b);
    b.sample = 32'h0;                          pending_beats.push_back(b);
    b.sample = 32'hAAAA_5555;                  pending_beats.push_back(b);
    b.sample = 32'h5555_AAAA;                  pending_beats.push_back(b);
    b.first = 1'b1; b.sample = 32'h0001_0000;  pending_beats.push_back(b);
    b.first = 1'b0;
    repeat (5) pending_beats.push_back(b);
    b.first = 1'b1;                            pending_beats.push_back(b);
    b.sample = 32'h8000_0000;                  pending_beats.push_back(b);
    wait_empty();

    // zero target and zero cap factor: every sample stops on the cap
    set_reg(REG_TARGET, 16'd0);
    queue_random(6);
    wait_empty();
    set_reg(REG_TARGET, 16'd1);
    set_reg(REG_CAP, 16'd0);
    queue_random(6);
    wait_empty();

    // cap disabled, extreme gains
    set_reg(REG_CAP, 16'h07FF);
    set_reg(REG_TARGET, 16'd2);
    set_reg(REG_GAIN, 16'hFFFF);
    set_reg(REG_MAXERR, 16'hFFFF);
    set_reg(REG_QUANT, 16'd0);
    queue_random(20);
    wait_empty();
    set_reg(REG_GAIN, 16'd0);
    set_reg(REG_MAXERR, 16'd1);
    set_reg(REG_QUANT, 16'hFFFF);
    queue_random(20);
    wait_empty();
    set_reg(REG_TARGET, 16'hFFFF);
    set_reg(REG_CAP, 16'd1023);
    queue_random(20);
    wait_empty();

    // random settings over the idling phases
    for (int ph = 0; ph < 8; ph++) begin
      set_reg(REG_TARGET, 16'($urandom_range(8, 1)));
      set_reg(REG_CAP, ($urandom_range(4, 0) == 0) ? 16'h07FF : 16'($urandom_range(4, 1)));
      set_reg(REG_GAIN, 16'($urandom_range(8192, 256)));
      set_reg(REG_MAXERR, 16'($urandom_range(1024, 50)));
      set_reg(REG_QUANT, 16'($urandom_range(16384, 2000)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      if (ph == 4) long_hold_req = 1'b1;  // receiver holds off while beats keep coming
      queue_random(180);
      wait_empty();  // sender pauses until all results are in
    end

    if (fail_count == 0) begin
      $display("[adaptive_sample_stop] OK");
    end else begin
      $display("[adaptive_sample_stop] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ass_pkg.sv
rtl/ass_if.sv
rtl/ass_alu.sv
rtl/ass_core.sv
rtl/adaptive_sample_stop.sv
sim/adaptive_sample_stop_test.sv
